### rtl/swt_pkg.sv
// Shared types and constants for the segment/circle wall test.
// No dependencies; imported by every module of the block.
package swt_pkg;

   localparam int MAX_CIRCLES = 128;
   localparam int ADDR_W      = $clog2(MAX_CIRCLES);
   localparam int CNT_W       = $clog2(MAX_CIRCLES + 1);
   localparam int COORD_W     = 12;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] radius;
   } circle_type;

   typedef struct packed {
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
   } segment_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } test_result_type;

endpackage

### rtl/swt_circle_ram.sv
// Circle table: RAM with one write port and one registered read port.
// Depends on swt_pkg.
module swt_circle_ram (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [swt_pkg::ADDR_W-1:0] wr_addr,
   input  swt_pkg::circle_type       wr_data,
   input  logic                      rd_en,
   input  logic [swt_pkg::ADDR_W-1:0] rd_addr,
   output swt_pkg::circle_type       rd_data,
   output logic                      rd_valid
);
   import swt_pkg::*;

   circle_type mem [MAX_CIRCLES];
   circle_type rd_data_ff;
   logic       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

### rtl/swt_circle_test.sv
// Four-stage pipelined boundary test of one circle against the segment.
// Depends on swt_pkg.
module swt_circle_test (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  swt_pkg::circle_type     circle,
   input  swt_pkg::segment_type    seg,
   output swt_pkg::test_result_type result,
   output logic                    busy
);
   import swt_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1: differences and products
   logic signed [12:0] wx, wy, vx, vy, dx, dy;
   logic signed [25:0] wx2_ff, wy2_ff, vx2_ff, vy2_ff, dx2_ff, dy2_ff;
   logic signed [25:0] wxdx_ff, wydy_ff, dxwy_ff, dywx_ff;
   logic [23:0]        r2_1_ff;

   assign wx = $signed({1'b0, circle.x}) - $signed({1'b0, seg.ax});
   assign wy = $signed({1'b0, circle.y}) - $signed({1'b0, seg.ay});
   assign vx = $signed({1'b0, circle.x}) - $signed({1'b0, seg.bx});
   assign vy = $signed({1'b0, circle.y}) - $signed({1'b0, seg.by});
   assign dx = $signed({1'b0, seg.bx}) - $signed({1'b0, seg.ax});
   assign dy = $signed({1'b0, seg.by}) - $signed({1'b0, seg.ay});

   always_ff @(posedge clock) begin
      wx2_ff  <= wx * wx;
      wy2_ff  <= wy * wy;
      vx2_ff  <= vx * vx;
      vy2_ff  <= vy * vy;
      dx2_ff  <= dx * dx;
      dy2_ff  <= dy * dy;
      wxdx_ff <= wx * dx;
      wydy_ff <= wy * dy;
      dxwy_ff <= dx * wy;
      dywx_ff <= dy * wx;
      r2_1_ff <= circle.radius * circle.radius;
   end

   // stage 2: sums
   logic signed [27:0] da_ff, db_ff, len2_ff, dot_ff, cross_ff;
   logic [23:0]        r2_2_ff;

   always_ff @(posedge clock) begin
      da_ff    <= 28'(wx2_ff) + 28'(wy2_ff);
      db_ff    <= 28'(vx2_ff) + 28'(vy2_ff);
      len2_ff  <= 28'(dx2_ff) + 28'(dy2_ff);
      dot_ff   <= 28'(wxdx_ff) + 28'(wydy_ff);
      cross_ff <= 28'(dxwy_ff) - 28'(dywx_ff);
      r2_2_ff  <= r2_1_ff;
   end

   // stage 3: squares and compares
   logic signed [27:0] r2s;
   logic signed [55:0] crossq_ff, rlen_ff;
   logic in_a_ff, in_b_ff, on_a_ff, on_b_ff, len0_ff, dot_lo_ff, dot_hi_ff;

   assign r2s = $signed({4'b0, r2_2_ff});

   always_ff @(posedge clock) begin
      crossq_ff <= cross_ff * cross_ff;
      rlen_ff   <= r2s * len2_ff;
      in_a_ff   <= da_ff < r2s;
      in_b_ff   <= db_ff < r2s;
      on_a_ff   <= da_ff <= r2s;
      on_b_ff   <= db_ff <= r2s;
      len0_ff   <= len2_ff == 28'sd0;
      dot_lo_ff <= dot_ff <= 28'sd0;
      dot_hi_ff <= dot_ff >= len2_ff;
   end

   // stage 4: decision
   logic hit_in, hit_ff;

   always_comb begin
      if (in_a_ff != in_b_ff) begin
         hit_in = 1'b1;
      end else if (in_a_ff) begin
         hit_in = 1'b0;
      end else if (len0_ff || dot_lo_ff) begin
         hit_in = on_a_ff;
      end else if (dot_hi_ff) begin
         hit_in = on_b_ff;
      end else begin
         hit_in = crossq_ff <= rlen_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign result.valid = v4_ff;
   assign result.hit   = hit_ff;
   assign busy         = in_valid | v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

### rtl/segment_circle_wall_test_core.sv
// Segment/circle wall test: top level with request control and response register.
// Depends on swt_pkg, swt_circle_ram and swt_circle_test.
//
// Requests arrive on req_* (tuser = action); every request gives one response on
// rsp_*: tdata bit 0 blocked, bit 1 status (append dropped because table full).
// Clear and append complete in the cycle they are accepted; the response shows
// on the next cycle.
// A query reads the circle table one entry per cycle through the memory's read
// port into a four-stage test pipeline; once the pipeline has drained, the
// response register is loaded (an empty table goes straight to the response).
// One request is in service at a time, so a query holds off new requests while
// it scans the whole table through the single table read port.
// Reset empties the table (count to zero) and drops any pending response.
// While the receiver stalls, the response register holds its value and no
// further request is taken until it is free.
module segment_circle_wall_test_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // circle_x, circle_y, circle_radius, first_x, first_y, second_x, second_y, pad
   input  logic [87:0] req_tdata,
   // action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // blocked, status, pad
   output logic [7:0]  rsp_tdata
);
   import swt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               hit_ff, hit_in;
   segment_type        seg_ff, seg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_blocked_ff, rsp_blocked_in;
   logic               rsp_status_ff, rsp_status_in;

   circle_type         wr_data, rd_data;
   logic               wr_en, rd_en, rd_valid, busy;
   test_result_type    result;
   action_type         action;
   logic               accept, rsp_free;

   assign action   = action_type'(req_tuser);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign accept   = req_tvalid && req_tready;

   assign wr_data.x      = req_tdata[11:0];
   assign wr_data.y      = req_tdata[23:12];
   assign wr_data.radius = req_tdata[35:24];
   assign wr_en = accept && (action == ACT_APPEND) && (count_ff < CNT_W'(MAX_CIRCLES));
   assign rd_en = (state_ff == ST_SCAN);

   swt_circle_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[ADDR_W-1:0]),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (idx_ff[ADDR_W-1:0]),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   swt_circle_test u_test (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid),
      .circle   (rd_data),
      .seg      (seg_ff),
      .result   (result),
      .busy     (busy)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      hit_in         = hit_ff | (result.valid & result.hit);
      seg_in         = seg_ff;
      rsp_valid_in   = rsp_valid_ff & !rsp_tready;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_status_in  = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_CLEAR: begin
                     count_in       = '0;
                     rsp_valid_in   = 1'b1;
                     rsp_blocked_in = 1'b0;
                     rsp_status_in  = 1'b0;
                  end
                  ACT_APPEND: begin
                     rsp_valid_in   = 1'b1;
                     rsp_blocked_in = 1'b0;
                     rsp_status_in  = !wr_en;
                     if (wr_en) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     seg_in.ax = req_tdata[47:36];
                     seg_in.ay = req_tdata[59:48];
                     seg_in.bx = req_tdata[71:60];
                     seg_in.by = req_tdata[83:72];
                     idx_in    = '0;
                     hit_in    = 1'b0;
                     state_in  = (count_ff == '0) ? ST_RESP : ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_blocked_in = 1'b0;
                     rsp_status_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == count_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_blocked_in = hit_ff;
               rsp_status_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      hit_ff         <= hit_in;
      seg_ff         <= seg_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_blocked_ff};

endmodule

### rtl/swt_checker.sv
// Port-level checks for the wall test core, attached by bind.
// Depends on swt_pkg and segment_circle_wall_test_core.
module swt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   import swt_pkg::*;

   logic accept;
   assign accept = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response present after reset");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("blocked and status both set");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == ACT_CLEAR || req_tuser == ACT_APPEND) |=>
      rsp_tvalid && !rsp_tdata[0])
      else $error("clear or append response missing");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == ACT_QUERY |=> !req_tready)
      else $error("request taken while query in service");

endmodule

bind segment_circle_wall_test_core swt_checker u_swt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/segment_circle_wall_test_core_tb.sv
// Testbench for segment_circle_wall_test_core: drives clear, append and query requests
// and checks each response against an integer wall-test predictor. Depends on swt_pkg.
module segment_circle_wall_test_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = ACT_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   typedef struct packed {
      logic blocked;
      logic status;
   } answer_type;

   circle_type   walls[MAX_CIRCLES];
   int           wall_count = 0;
   answer_type   pending_answers[$];
   int           errors = 0;
   int           cycles = 0;
   int           burst_left = 0;
   int           stall_mode = 0;

   segment_circle_wall_test_core DUT (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic bit wall_hit(circle_type c, segment_type s);
      longint cx, cy, r2, ax, ay, bx, by, da, db, dx, dy, wx, wy, len2, dot, cr;
      bit in_a, in_b;
      cx = c.x; cy = c.y; r2 = longint'(c.radius) * c.radius;
      ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
      da = (ax - cx) * (ax - cx) + (ay - cy) * (ay - cy);
      db = (bx - cx) * (bx - cx) + (by - cy) * (by - cy);
      in_a = da < r2;
      in_b = db < r2;
      if (in_a != in_b) return 1'b1;
      if (in_a) return 1'b0;
      dx = bx - ax; dy = by - ay; wx = cx - ax; wy = cy - ay;
      len2 = dx * dx + dy * dy;
      if (len2 == 0) return da <= r2;
      dot = wx * dx + wy * dy;
      if (dot <= 0) return da <= r2;
      if (dot >= len2) return db <= r2;
      cr = dx * wy - dy * wx;
      return cr * cr <= r2 * len2;
   endfunction

   function automatic answer_type predict_answer(action_type act, circle_type c,
                                                 segment_type s);
      answer_type a;
      a = '0;
      case (act)
         ACT_CLEAR: wall_count = 0;
         ACT_APPEND: begin
            if (wall_count < MAX_CIRCLES) begin
               walls[wall_count] = c;
               wall_count++;
            end else begin
               a.status = 1'b1;
            end
         end
         ACT_QUERY: begin
            for (int i = 0; i < wall_count; i++)
               if (wall_hit(walls[i], s)) begin
                  a.blocked = 1'b1;
                  break;
               end
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic send_request(action_type act, circle_type c, segment_type s);
      logic [83:0] payload;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      payload = {s.by, s.bx, s.ay, s.ax, c.radius, c.y, c.x};
      req_tdata  <= {4'b0, payload};
      req_tuser  <= act;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_answers.push_back(predict_answer(act, c, s));
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic circle_type rand_circle(int rmax);
      circle_type c;
      c.x = 12'($urandom_range(0, 4095));
      c.y = 12'($urandom_range(0, 4095));
      c.radius = 12'($urandom_range(0, rmax));
      return c;
   endfunction

   function automatic segment_type rand_segment(int span);
      segment_type s;
      s.ax = 12'($urandom_range(0, 4095));
      s.ay = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 9) == 0) begin
         s.bx = s.ax; s.by = s.ay;
      end else begin
         s.bx = 12'($urandom_range(0, 4095));
         s.by = 12'($urandom_range(0, 4095));
         if ($urandom_range(0, 1)) begin
            s.bx = 12'((int'(s.ax) + $urandom_range(0, 2 * span) - span) & 12'hfff);
            s.by = 12'((int'(s.ay) + $urandom_range(0, 2 * span) - span) & 12'hfff);
         end
      end
      return s;
   endfunction

   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= cycles[4];
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected response: expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            answer_type exp_a;
            exp_a = pending_answers.pop_front();
            if (rsp_tdata[0] !== exp_a.blocked || rsp_tdata[1] !== exp_a.status ||
                rsp_tdata[7:2] !== 6'b0)
               begin
               $display("%0t mismatch: expected blocked=%b status=%b, actual %h",
                        $time, exp_a.blocked, exp_a.status, rsp_tdata);
               errors++;
            end
         end
      end
   end

   task automatic test_directed;
      circle_type c;
      segment_type s;
      c = '0; s = '0;
      send_request(ACT_QUERY, c, s);
      c = '{x: 12'd100, y: 12'd100, radius: 12'd10};
      send_request(ACT_APPEND, c, s);
      s = '{ax: 12'd100, ay: 12'd100, bx: 12'd100, by: 12'd100};
      send_request(ACT_QUERY, c, s);
      s = '{ax: 12'd100, ay: 12'd100, bx: 12'd200, by: 12'd100};
      send_request(ACT_QUERY, c, s);
      s = '{ax: 12'd90, ay: 12'd0, bx: 12'd90, by: 12'd300};
      send_request(ACT_QUERY, c, s);
      s = '{ax: 12'd110, ay: 12'd100, bx: 12'd110, by: 12'd100};
      send_request(ACT_QUERY, c, s);
      s = '{ax: 12'd100, ay: 12'd110, bx: 12'd100, by: 12'd300};
      send_request(ACT_QUERY, c, s);
      s = '{ax: 12'd89, ay: 12'd0, bx: 12'd89, by: 12'd300};
      send_request(ACT_QUERY, c, s);
      s = '{ax: 12'd0, ay: 12'd0, bx: 12'd4095, by: 12'd4095};
      send_request(ACT_QUERY, c, s);
      c = '{x: 12'd4095, y: 12'd4095, radius: 12'd4095};
      send_request(ACT_APPEND, c, s);
      s = '{ax: 12'd4095, ay: 12'd0, bx: 12'd0, by: 12'd4095};
      send_request(ACT_QUERY, c, s);
      c = '0;
      send_request(ACT_APPEND, c, s);
      send_request(ACT_NONE, '1, '1);
      send_request(ACT_QUERY, '1, '1);
      send_request(ACT_CLEAR, '1, '1);
      send_request(ACT_QUERY, c, s);
      drain();
   endtask

   task automatic test_full_table;
      send_request(ACT_CLEAR, '0, '0);
      for (int i = 0; i < MAX_CIRCLES + 3; i++)
         send_request(ACT_APPEND, rand_circle(300), rand_segment(0));
      for (int i = 0; i < 20; i++) send_request(ACT_QUERY, '0, rand_segment(500));
      drain();
   endtask

   task automatic test_random;
      int n;
      for (int k = 0; k < 1780; k++) begin
         n = $urandom_range(0, 99);
         if (n < 3) send_request(ACT_CLEAR, rand_circle(4095), rand_segment(4095));
         else if (n < 5) send_request(ACT_NONE, rand_circle(4095), rand_segment(4095));
         else if (n < 40 && wall_count < 12)
            send_request(ACT_APPEND, rand_circle(n < 10 ? 4095 : 400), rand_segment(0));
         else if (n < 42) send_request(ACT_APPEND, rand_circle(4095), rand_segment(4095));
         else send_request(ACT_QUERY, rand_circle(4095),
                           rand_segment(n < 70 ? 300 : 4095));
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

### segment_circle_wall_test_core.f
rtl/swt_pkg.sv
rtl/swt_circle_ram.sv
rtl/swt_circle_test.sv
rtl/segment_circle_wall_test_core.sv
rtl/swt_checker.sv
tb/sv/segment_circle_wall_test_core_tb.sv
